// ===== src/ptat_pkg.sv =====
// ============================================================================
// ptat_pkg
// Shared types, character codes and the decimal conversion for the 24-bit
// background color encoder.
// ============================================================================
`default_nettype none

package ptat_pkg;

    // Input beat: one RGB pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_in_row;
    } ptat_pixel_t;

    // Result beat: one text byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } ptat_result_t;

    // One color component as decimal digits, ndig counts significant digits
    typedef struct packed {
        logic [1:0] ndig;
        logic [3:0] hun;
        logic [3:0] ten;
        logic [3:0] uni;
    } ptat_dec_t;

    // Classified pixel handed from the front end to the byte sequencer
    typedef struct packed {
        logic      emit_seq;
        logic      last_in_row;
        ptat_dec_t red;
        ptat_dec_t green;
        ptat_dec_t blue;
    } ptat_cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } ptat_q_status_t;

    // Sequencer phases, one per emitted byte (digits repeat their phase)
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ESC,
        PH_BRACKET,
        PH_FOUR,
        PH_EIGHT,
        PH_SEMI_A,
        PH_TWO,
        PH_SEMI_B,
        PH_RED,
        PH_SEMI_C,
        PH_GREEN,
        PH_SEMI_D,
        PH_BLUE,
        PH_M,
        PH_SPACE,
        PH_NEWLINE
    } ptat_phase_t;

    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_FOUR    = 8'h34;
    localparam logic [7:0] CH_EIGHT   = 8'h38;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_M       = 8'h6D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    // Split an 8-bit value into hundreds, tens and units
    function automatic ptat_dec_t ptat_to_dec(input logic [7:0] v);
        ptat_dec_t  d;
        logic [1:0] h;
        logic [6:0] rem;
        logic [14:0] prod;
        logic [3:0] t;
        logic [6:0] u7;
        if (v >= 8'd200) begin
            h   = 2'd2;
            rem = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            h   = 2'd1;
            rem = 7'(v - 8'd100);
        end else begin
            h   = 2'd0;
            rem = v[6:0];
        end
        // rem / 10 by reciprocal, exact for rem below 100
        prod  = {8'b0, rem} * 15'd205;
        t     = prod[14:11];
        u7    = rem - 7'({3'b0, t} * 7'd10);
        d.hun = {2'b0, h};
        d.ten = t;
        d.uni = u7[3:0];
        if (h != 2'd0) begin
            d.ndig = 2'd3;
        end else if (t != 4'd0) begin
            d.ndig = 2'd2;
        end else begin
            d.ndig = 2'd1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== src/ptat_front.sv =====
// ============================================================================
// ptat_front
// Accepts pixels, compares them with the held color and converts the
// components to decimal digits; pushes one command per pixel.
// ============================================================================
`default_nettype none

module ptat_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ptat_pkg::ptat_pixel_t pixel,
    input  wire logic                 push,
    output logic                      full,
    input  wire ptat_pkg::ptat_q_status_t q_status,
    output logic                      q_push,
    output ptat_pkg::ptat_cmd_t       q_data
);

    logic [7:0] held_red_reg;
    logic [7:0] held_green_reg;
    logic [7:0] held_blue_reg;
    logic       colour_held_reg;
    logic       accept;
    logic       differs;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;
    assign q_push = accept;

    // Decide whether the color select sequence is needed
    assign differs = !colour_held_reg
                  || (pixel.red != held_red_reg)
                  || (pixel.green != held_green_reg)
                  || (pixel.blue != held_blue_reg);

    // Build the command for the sequencer
    always_comb
    begin
        q_data.emit_seq    = differs;
        q_data.last_in_row = pixel.last_in_row;
        q_data.red         = ptat_pkg::ptat_to_dec(pixel.red);
        q_data.green       = ptat_pkg::ptat_to_dec(pixel.green);
        q_data.blue        = ptat_pkg::ptat_to_dec(pixel.blue);
    end

    // Hold the current row color; drop it at the end of a row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_red_reg    <= 8'd0;
            held_green_reg  <= 8'd0;
            held_blue_reg   <= 8'd0;
            colour_held_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (differs)
            begin
                held_red_reg    <= pixel.red;
                held_green_reg  <= pixel.green;
                held_blue_reg   <= pixel.blue;
            end
            colour_held_reg <= !pixel.last_in_row;
        end
    end

endmodule

`default_nettype wire

// ===== src/ptat_fifo.sv =====
// ============================================================================
// ptat_fifo
// Short command queue between the front end and the byte sequencer.
// ============================================================================
`default_nettype none

module ptat_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire ptat_pkg::ptat_cmd_t wr_data,
    input  wire logic                rd_en,
    output ptat_pkg::ptat_cmd_t      rd_data,
    output ptat_pkg::ptat_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptat_pkg::ptat_cmd_t slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_wr;
    logic                do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = slot_reg[rd_ptr_reg];

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ptat_back.sv =====
// ============================================================================
// ptat_back
// Byte sequencer: walks one command through its text bytes, one byte per
// cycle unless the output is held, into a single-entry output register.
// ============================================================================
`default_nettype none

module ptat_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ptat_pkg::ptat_q_status_t q_status,
    input  wire ptat_pkg::ptat_cmd_t     q_data,
    output logic                         q_pop,
    input  wire logic                    pop,
    output logic                         empty,
    output ptat_pkg::ptat_result_t       result
);

    ptat_pkg::ptat_phase_t  state_reg;
    ptat_pkg::ptat_phase_t  state_next;
    ptat_pkg::ptat_phase_t  start_phase;
    ptat_pkg::ptat_cmd_t    cmd_reg;
    logic [1:0]             dig_reg;
    logic [1:0]             dig_next;
    logic                   out_valid_reg;
    ptat_pkg::ptat_result_t out_reg;
    logic                   adv;
    logic                   load;
    logic                   item_done;
    logic                   emit;
    ptat_pkg::ptat_dec_t    comp;
    logic [1:0]             pos;
    logic [3:0]             digit;
    logic                   dig_last;
    logic [7:0]             byte_val;
    logic                   final_val;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign adv    = !out_valid_reg || pop;
    assign emit   = (state_reg != ptat_pkg::PH_IDLE) && adv;
    assign q_pop  = load;
    assign start_phase = q_data.emit_seq ? ptat_pkg::PH_ESC : ptat_pkg::PH_SPACE;

    // Select the component and digit in play
    always_comb
    begin
        if (state_reg == ptat_pkg::PH_RED)
        begin
            comp = cmd_reg.red;
        end
        else if (state_reg == ptat_pkg::PH_GREEN)
        begin
            comp = cmd_reg.green;
        end
        else
        begin
            comp = cmd_reg.blue;
        end
        pos      = dig_reg + (2'd3 - comp.ndig);
        dig_last = (dig_reg == comp.ndig - 2'd1);
        if (pos == 2'd0)
        begin
            digit = comp.hun;
        end
        else if (pos == 2'd1)
        begin
            digit = comp.ten;
        end
        else
        begin
            digit = comp.uni;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        load       = 1'b0;
        item_done  = 1'b0;
        unique case (state_reg)
            ptat_pkg::PH_IDLE:
            begin
                if (!q_status.empty)
                begin
                    load       = 1'b1;
                    state_next = start_phase;
                end
            end
            ptat_pkg::PH_ESC:     if (adv) state_next = ptat_pkg::PH_BRACKET;
            ptat_pkg::PH_BRACKET: if (adv) state_next = ptat_pkg::PH_FOUR;
            ptat_pkg::PH_FOUR:    if (adv) state_next = ptat_pkg::PH_EIGHT;
            ptat_pkg::PH_EIGHT:   if (adv) state_next = ptat_pkg::PH_SEMI_A;
            ptat_pkg::PH_SEMI_A:  if (adv) state_next = ptat_pkg::PH_TWO;
            ptat_pkg::PH_TWO:     if (adv) state_next = ptat_pkg::PH_SEMI_B;
            ptat_pkg::PH_SEMI_B:  if (adv) state_next = ptat_pkg::PH_RED;
            ptat_pkg::PH_SEMI_C:  if (adv) state_next = ptat_pkg::PH_GREEN;
            ptat_pkg::PH_SEMI_D:  if (adv) state_next = ptat_pkg::PH_BLUE;
            ptat_pkg::PH_M:       if (adv) state_next = ptat_pkg::PH_SPACE;
            ptat_pkg::PH_RED, ptat_pkg::PH_GREEN, ptat_pkg::PH_BLUE:
            begin
                if (adv)
                begin
                    if (dig_last)
                    begin
                        dig_next = 2'd0;
                        if (state_reg == ptat_pkg::PH_RED)
                        begin
                            state_next = ptat_pkg::PH_SEMI_C;
                        end
                        else if (state_reg == ptat_pkg::PH_GREEN)
                        begin
                            state_next = ptat_pkg::PH_SEMI_D;
                        end
                        else
                        begin
                            state_next = ptat_pkg::PH_M;
                        end
                    end
                    else
                    begin
                        dig_next = dig_reg + 2'd1;
                    end
                end
            end
            ptat_pkg::PH_SPACE:
            begin
                if (adv)
                begin
                    if (cmd_reg.last_in_row)
                    begin
                        state_next = ptat_pkg::PH_NEWLINE;
                    end
                    else
                    begin
                        item_done = 1'b1;
                    end
                end
            end
            ptat_pkg::PH_NEWLINE:
            begin
                if (adv)
                begin
                    item_done = 1'b1;
                end
            end
            default:
            begin
                state_next = ptat_pkg::PH_IDLE;
            end
        endcase
        // Chain straight into the next command when one waits
        if (item_done)
        begin
            if (!q_status.empty)
            begin
                load       = 1'b1;
                state_next = start_phase;
            end
            else
            begin
                state_next = ptat_pkg::PH_IDLE;
            end
        end
    end

    // Byte for the current phase
    always_comb
    begin
        final_val = 1'b0;
        unique case (state_reg)
            ptat_pkg::PH_ESC:     byte_val = ptat_pkg::CH_ESC;
            ptat_pkg::PH_BRACKET: byte_val = ptat_pkg::CH_BRACKET;
            ptat_pkg::PH_FOUR:    byte_val = ptat_pkg::CH_FOUR;
            ptat_pkg::PH_EIGHT:   byte_val = ptat_pkg::CH_EIGHT;
            ptat_pkg::PH_TWO:     byte_val = ptat_pkg::CH_TWO;
            ptat_pkg::PH_M:       byte_val = ptat_pkg::CH_M;
            ptat_pkg::PH_SEMI_A, ptat_pkg::PH_SEMI_B,
            ptat_pkg::PH_SEMI_C, ptat_pkg::PH_SEMI_D:
                byte_val = ptat_pkg::CH_SEMI;
            ptat_pkg::PH_RED, ptat_pkg::PH_GREEN, ptat_pkg::PH_BLUE:
                byte_val = ptat_pkg::CH_ZERO + {4'b0, digit};
            ptat_pkg::PH_SPACE:
            begin
                byte_val  = ptat_pkg::CH_SPACE;
                final_val = !cmd_reg.last_in_row;
            end
            ptat_pkg::PH_NEWLINE:
            begin
                byte_val  = ptat_pkg::CH_NEWLINE;
                final_val = 1'b1;
            end
            default:              byte_val = ptat_pkg::CH_SPACE;
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptat_pkg::PH_IDLE;
            dig_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dig_reg   <= dig_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the command and the outgoing byte
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= q_data;
        end
        if (emit)
        begin
            out_reg.text_byte  <= byte_val;
            out_reg.final_byte <= final_val;
        end
    end

endmodule

`default_nettype wire

// ===== src/pixel_to_ansi_truecolor_unit.sv =====
// ============================================================================
// pixel_to_ansi_truecolor_unit
// Turns RGB pixels into terminal text with 24-bit background color selects.
// ============================================================================
// Each pixel produces 1 to 21 bytes: the select sequence ESC [ 4 8 ; 2 ; R ; G ; B m
// when the color changes or the row has no color yet, then a space, then a
// newline on the last pixel of a row. Bytes leave at one per cycle while the
// receiver keeps popping, through a single output register. After the block
// has run dry, a pixel's first byte passes through the command queue, the
// sequencer's command register and the output register. Pixels are classified
// on entry and parked in a QUEUE_DEPTH-entry command queue, so the input keeps
// accepting while earlier pixels are still being written out.
`default_nettype none

module pixel_to_ansi_truecolor_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire ptat_pkg::ptat_pixel_t  pixel,
    input  wire logic                   pop,
    output logic                        empty,
    output ptat_pkg::ptat_result_t      result
);

    ptat_pkg::ptat_q_status_t q_status;
    ptat_pkg::ptat_cmd_t      q_wr_data;
    ptat_pkg::ptat_cmd_t      q_rd_data;
    logic                     q_push;
    logic                     q_pop;

    // Classify incoming pixels
    ptat_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel),
        .push     (push),
        .full     (full),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    // Decouple the two sides
    ptat_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // Write out the bytes
    ptat_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_rd_data),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

    // An accepted pixel is in the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !q_status.empty)
        else $error("accepted pixel missing from command queue");

    // The sequencer never takes from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("command taken from empty queue");

    // A pixel's last byte is always a space or a newline
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.final_byte) |->
            (result.text_byte == ptat_pkg::CH_SPACE
             || result.text_byte == ptat_pkg::CH_NEWLINE))
        else $error("final byte is not a space or newline");

    // The escape byte opens a sequence and never closes a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.text_byte == ptat_pkg::CH_ESC) |-> !result.final_byte)
        else $error("escape byte marked final");

endmodule

`default_nettype wire

// ===== dv/ptat_checker.sv =====
// ============================================================================
// ptat_checker
// Watches the pixel and text channels of the truecolor encoder, predicts the
// byte stream of every accepted pixel and compares each accepted text beat.
// ============================================================================
`default_nettype none

module ptat_checker (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire logic                   full,
    input  wire ptat_pkg::ptat_pixel_t  pixel,
    input  wire logic                   pop,
    input  wire logic                   empty,
    input  wire ptat_pkg::ptat_result_t result,
    input  wire logic                   wrap_up,
    output int                          errors,
    output int                          pending,
    output int                          bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted text bytes, oldest first
    ptat_pkg::ptat_result_t expected_bytes[$];

    // Color the current row is painted with
    logic [7:0] row_red;
    logic [7:0] row_green;
    logic [7:0] row_blue;
    logic       row_color_valid;

    initial begin
        errors          = 0;
        pending         = 0;
        bytes_checked   = 0;
        row_red         = 8'd0;
        row_green       = 8'd0;
        row_blue        = 8'd0;
        row_color_valid = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH at text byte %0d: %s", $realtime, bytes_checked, what);
        errors++;
    endtask

    task automatic add_byte(input logic [7:0] ch, input logic last_one);
        ptat_pkg::ptat_result_t r;
        r.text_byte  = ch;
        r.final_byte = last_one;
        expected_bytes.push_back(r);
    endtask

    // Append a component as decimal text, no leading zeros
    task automatic add_decimal(input logic [7:0] v);
        int hun;
        int ten;
        int uni;
        hun = v / 100;
        ten = (v / 10) % 10;
        uni = v % 10;
        if (hun != 0)
            add_byte(8'(ptat_pkg::CH_ZERO + hun), 1'b0);
        if (hun != 0 || ten != 0)
            add_byte(8'(ptat_pkg::CH_ZERO + ten), 1'b0);
        add_byte(8'(ptat_pkg::CH_ZERO + uni), 1'b0);
    endtask

    // Predict the text of one pixel and advance the row color
    task automatic encode_pixel(input ptat_pkg::ptat_pixel_t px);
        if (!row_color_valid || px.red != row_red || px.green != row_green
            || px.blue != row_blue)
        begin
            add_byte(ptat_pkg::CH_ESC, 1'b0);
            add_byte(ptat_pkg::CH_BRACKET, 1'b0);
            add_byte(ptat_pkg::CH_FOUR, 1'b0);
            add_byte(ptat_pkg::CH_EIGHT, 1'b0);
            add_byte(ptat_pkg::CH_SEMI, 1'b0);
            add_byte(ptat_pkg::CH_TWO, 1'b0);
            add_byte(ptat_pkg::CH_SEMI, 1'b0);
            add_decimal(px.red);
            add_byte(ptat_pkg::CH_SEMI, 1'b0);
            add_decimal(px.green);
            add_byte(ptat_pkg::CH_SEMI, 1'b0);
            add_decimal(px.blue);
            add_byte(ptat_pkg::CH_M, 1'b0);
            row_red         = px.red;
            row_green       = px.green;
            row_blue        = px.blue;
            row_color_valid = 1'b1;
        end
        add_byte(ptat_pkg::CH_SPACE, !px.last_in_row);
        if (px.last_in_row) begin
            add_byte(ptat_pkg::CH_NEWLINE, 1'b1);
            row_color_valid = 1'b0;
        end
    endtask

    // Compare an accepted text beat with the oldest prediction
    task automatic check_text(input ptat_pkg::ptat_result_t got);
        ptat_pkg::ptat_result_t want;
        if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte 0x%02h final %0b",
                                      got.text_byte, got.final_byte));
        end else begin
            want = expected_bytes.pop_front();
            if (got.text_byte !== want.text_byte)
                report_mismatch($sformatf("text_byte 0x%02h, want 0x%02h",
                                          got.text_byte, want.text_byte));
            if (got.final_byte !== want.final_byte)
                report_mismatch($sformatf("final_byte %0b, want %0b",
                                          got.final_byte, want.final_byte));
        end
        bytes_checked++;
    endtask

    // Sample both channels at the clock edge, output side first
    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty)
                check_text(result);
            if (push && !full)
                encode_pixel(pixel);
            pending = expected_bytes.size();
        end
    end

    // Flag predictions that never arrived
    always @(posedge wrap_up) begin
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d predicted bytes never arrived",
                                      expected_bytes.size()));
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ============================================================================
// testbench
// Drives pixels into the truecolor encoder and drains its text stream with
// random gaps on both sides; the checker predicts and compares every byte.
// ============================================================================
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_PIXELS  = 100;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int IDLE_LIMIT     = 4000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    ptat_pkg::ptat_pixel_t  pixel = '0;
    logic                   pop = 1'b0;
    logic                   empty;
    ptat_pkg::ptat_result_t result;
    logic                   wrap_up = 1'b0;
    logic                   hold_output = 1'b0;

    int errors;
    int pending;
    int bytes_checked;
    int pixels_sent = 0;
    int rows_sent = 0;
    int idle_cycles = 0;
    int send_burst = 0;

    pixel_to_ansi_truecolor_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .pixel  (pixel),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    ptat_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .pixel         (pixel),
        .pop           (pop),
        .empty         (empty),
        .result        (result),
        .wrap_up       (wrap_up),
        .errors        (errors),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    always #5 clk = ~clk;

    // Gap before a beat: mostly none or short, a few long, with bursts of none
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 5) begin
            burst = $urandom_range(40, 20);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic ptat_pkg::ptat_pixel_t make_pixel(input logic [7:0] r,
                                                         input logic [7:0] g,
                                                         input logic [7:0] b,
                                                         input logic last);
        ptat_pkg::ptat_pixel_t px;
        px.red         = r;
        px.green       = g;
        px.blue        = b;
        px.last_in_row = last;
        return px;
    endfunction

    // Component with digit-count edges favored, else fully random
    function automatic logic [7:0] pick_component();
        logic [7:0] edges[10] = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd99, 8'd100,
                                  8'd199, 8'd200, 8'd250, 8'd255};
        if ($urandom_range(1) == 0)
            return edges[$urandom_range(9)];
        return 8'($urandom_range(255));
    endfunction

    // Offer one pixel and hold it until accepted
    task automatic send_pixel(input ptat_pkg::ptat_pixel_t px);
        int gap;
        gap = pick_gap(send_burst);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel <= px;
        push  <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        pixels_sent++;
        if (px.last_in_row)
            rows_sent++;
    endtask

    // Stop offering and wait until every predicted byte has come out
    task automatic drain_output();
        push <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Receiver: random gaps, one long hold when asked
    initial begin
        int  gap;
        int  recv_burst;
        bit  held_off;
        recv_burst = 0;
        held_off   = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_output && !held_off) begin
                held_off = 1'b1;
                gap = LONG_HOLD;
            end else begin
                gap = pick_gap(recv_burst);
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus and verdict
    initial begin
        ptat_pkg::ptat_pixel_t directed_pixels[$];
        logic [7:0]  cur_red;
        logic [7:0]  cur_green;
        logic [7:0]  cur_blue;
        int          random_sent;
        int          row_len;
        int          choice;

        // Hold reset, then release
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: row starts, repeats, digit-count edges, single-pixel rows
        directed_pixels.push_back(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
        directed_pixels.push_back(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
        directed_pixels.push_back(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
        directed_pixels.push_back(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
        directed_pixels.push_back(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
        directed_pixels.push_back(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
        directed_pixels.push_back(make_pixel(8'd9, 8'd10, 8'd99, 1'b0));
        directed_pixels.push_back(make_pixel(8'd100, 8'd200, 8'd5, 1'b0));
        directed_pixels.push_back(make_pixel(8'd10, 8'd0, 8'd255, 1'b1));
        directed_pixels.push_back(make_pixel(8'd255, 8'd255, 8'd255, 1'b1));
        directed_pixels.push_back(make_pixel(8'd255, 8'd255, 8'd255, 1'b1));
        directed_pixels.push_back(make_pixel(8'd99, 8'd100, 8'd9, 1'b0));
        directed_pixels.push_back(make_pixel(8'd99, 8'd100, 8'd8, 1'b0));
        directed_pixels.push_back(make_pixel(8'd98, 8'd100, 8'd8, 1'b0));
        directed_pixels.push_back(make_pixel(8'd98, 8'd101, 8'd8, 1'b1));
        directed_pixels.push_back(make_pixel(8'd170, 8'd85, 8'd170, 1'b0));
        directed_pixels.push_back(make_pixel(8'd85, 8'd170, 8'd85, 1'b1));
        directed_pixels.push_back(make_pixel(8'd1, 8'd2, 8'd3, 1'b0));
        directed_pixels.push_back(make_pixel(8'd1, 8'd2, 8'd3, 1'b1));
        foreach (directed_pixels[i])
            send_pixel(directed_pixels[i]);
        drain_output();

        // Random rows: repeats of the current color, edge values and noise
        cur_red     = 8'd0;
        cur_green   = 8'd0;
        cur_blue    = 8'd0;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            row_len = ($urandom_range(9) == 0) ? $urandom_range(30, 11)
                                               : $urandom_range(10, 1);
            for (int k = 0; k < row_len; k++) begin
                choice = $urandom_range(99);
                if (choice >= 45) begin
                    cur_red   = pick_component();
                    cur_green = pick_component();
                    cur_blue  = pick_component();
                end
                send_pixel(make_pixel(cur_red, cur_green, cur_blue, k == row_len - 1));
                random_sent++;
                // Stall the output for a long stretch while pixels keep coming
                if (random_sent == 15)
                    hold_output <= 1'b1;
                // Pause the input until the stream is drained
                if (random_sent == 80)
                    drain_output();
            end
        end

        // Drain and let the block settle
        drain_output();
        repeat (TAIL_CYCLES) @(posedge clk);
        wrap_up <= 1'b1;
        @(posedge clk);

        $display("Covered %0d pixels in %0d rows, %0d text bytes compared,",
                 pixels_sent, rows_sent, bytes_checked);
        $display("including a long output stall with the input backed up and a drained pause");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/ptat_pkg.sv
src/ptat_front.sv
src/ptat_fifo.sv
src/ptat_back.sv
src/pixel_to_ansi_truecolor_unit.sv
dv/ptat_checker.sv
dv/testbench.sv
